// ===== rtl/lobvl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Link output buffer package
// Shared constants, codes and command/status types.
// ----------------------------------------------------------------------------
package lobvl_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int NUM_VL      = 16;
   localparam int QA_W        = $clog2(QUEUE_DEPTH);
   localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);
   localparam int VL_W        = 4;
   localparam int ENTRY_W     = 37;

   localparam logic [1:0] OP_DATA   = 2'd0;
   localparam logic [1:0] OP_TICK   = 2'd1;
   localparam logic [1:0] OP_CREDIT = 2'd2;

   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_FC    = 2'd1;
   localparam logic [1:0] KIND_TOKEN = 2'd2;
   localparam logic [1:0] KIND_OVF   = 2'd3;

   localparam logic [1:0] PREV_NONE = 2'd0;
   localparam logic [1:0] PREV_DATA = 2'd1;
   localparam logic [1:0] PREV_LAST = 2'd2;
   localparam logic [1:0] PREV_FC   = 2'd3;

   localparam logic CSR_MAX_VL     = 1'b0;
   localparam logic CSR_QUEUE_SIZE = 1'b1;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  vl;
      logic [31:0] tag;
      logic        lst;
      logic [11:0] fcb;
      logic [11:0] fcl;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic        latch;     // capture input item
      logic        credit;    // store credit limit
      logic        enqueue;   // write flit to queue
      logic        ovf;       // emit overflow
      logic        direct;    // send input flit directly
      logic        tick;      // link ready processing start
      logic        token;     // emit free token
      logic        scan_init; // prepare scan
      logic        scan_step; // examine one lane
      logic        pop_read;  // read queue head
      logic        pop_send;  // send popped flit
      logic        idle_prev; // previous send becomes none
      logic        emit_last; // current emission is last
   } cmd_type;

   typedef struct packed {
      logic [1:0]  op;
      logic        busy;
      logic        full;
      logic        pend;
      logic        prev_data;
      logic        q_empty;
      logic        scan_hit;
      logic        scan_done;
   } sts_type;

endpackage
`default_nettype wire

// ===== rtl/link_output_buffer_with_vl_flow_control.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Link output buffer with virtual-lane flow control
// Queues data flits and inserts flow-control packets on link-ready ticks.
// ----------------------------------------------------------------------------
// Channel  Direction  Payload
// req      in         operation, vl, flit_tag, flit_last, credit_limit
// rsp      out        result words, tlast on the final one
// csr      in         register index and write data
// A tick may scan up to all sixteen lanes; the scan examines one lane per
// cycle, and a queue pop reads the RAM head in S_POP before it sends in S_SEND.
// Reset is synchronous; the queue RAM needs no clearing.
// A result held back by the receiver stalls the controller at its next result.
module link_output_buffer_with_vl_flow_control import lobvl_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // operation[1:0], vl[5:2], flit_tag[37:6], flit_last[38], credit_limit[50:39]
   input  wire logic [55:0] req_tdata,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // out_vl[3:0], out_tag[35:4], out_last_flit[36], fc_blocks_sent[48:37],
   // fc_credit_limit[60:49]
   output      logic [63:0] rsp_tdata,
   output      logic [1:0]  rsp_tuser, // result_kind
   output      logic        rsp_tlast,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic        csr_index,
   input  wire logic [4:0]  csr_data
);
   cmd_type cmd;
   sts_type sts;
   logic    rsp_load;
   rsp_type word;
   logic    valid_ff;
   logic    out_free;
   logic    in_fire;

   assign csr_ready = 1'b1;
   assign in_fire   = req_tvalid && req_tready;
   assign out_free  = !valid_ff || rsp_tready;

   lobvl_ctrl u_ctrl (
      .clock(clock), .reset(reset), .in_fire(in_fire), .out_free(out_free),
      .sts(sts), .in_ready(req_tready), .cmd(cmd)
   );

   lobvl_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .in_data(req_tdata[50:0]), .csr_we(csr_valid), .csr_idx(csr_index),
      .csr_val(csr_data), .rsp_load(rsp_load), .rsp_word(word)
   );

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (rsp_load) valid_ff <= 1'b1;
      else if (rsp_tready) valid_ff <= 1'b0;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = word.kind;
   assign rsp_tlast  = word.last;
   assign rsp_tdata  = {3'd0, word.fcl, word.fcb, word.lst, word.tag, word.vl};

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> !req_tready) else $error("input taken during result load");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_tready) |-> !rsp_load)
      else $error("result overwritten");
   a_hold_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("waiting result changed");
`endif
endmodule
`default_nettype wire

// ===== rtl/lobvl_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one registered read port.
// ----------------------------------------------------------------------------
module lobvl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ===== rtl/lobvl_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Link output buffer datapath
// Queue, lane counters, scan pointer and result register.
// ----------------------------------------------------------------------------
module lobvl_datapath import lobvl_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output      sts_type     sts,
   input  wire logic [50:0] in_data,
   input  wire logic        csr_we,
   input  wire logic        csr_idx,
   input  wire logic [4:0]  csr_val,
   output      logic        rsp_load,
   output      rsp_type     rsp_word
);
   logic [1:0]  op_ff;
   logic [3:0]  vl_ff;
   logic [31:0] tag_ff;
   logic        lst_ff;
   logic [11:0] cl_ff;
   logic [3:0]  max_vl_ff;
   logic [4:0]  qsize_ff;
   logic [QC_W-1:0] count_ff;
   logic [QA_W-1:0] head_ff;
   logic        busy_ff;
   logic [1:0]  prev_ff;
   logic [4:0]  ptr_ff;
   logic [4:0]  pend_ff;
   logic [11:0] bs_ff  [NUM_VL];
   logic [11:0] lim_ff [NUM_VL];
   logic [11:0] ab_ff  [NUM_VL];
   logic [11:0] al_ff  [NUM_VL];
   logic [NUM_VL-1:0] av_ff;
   logic [ENTRY_W-1:0] rd_data;
   logic [4:0]  top;
   logic [4:0]  cap;
   logic [QA_W-1:0] slot;
   logic [3:0]  si;
   logic        lane_ok;
   logic        changed;

   assign top  = (max_vl_ff > 4'(NUM_VL - 1)) ? 5'(NUM_VL - 1) : {1'b0, max_vl_ff};
   assign cap  = (qsize_ff > 5'(QUEUE_DEPTH)) ? 5'(QUEUE_DEPTH) : qsize_ff;
   assign slot = QA_W'((QC_W + 1)'(head_ff) + (QC_W + 1)'(count_ff));
   assign si   = ptr_ff[3:0];
   assign lane_ok = (32'(si) < NUM_VL);
   assign changed = lane_ok && (!av_ff[si] || ab_ff[si] != bs_ff[si] ||
                                al_ff[si] != lim_ff[si]);

   assign sts.op        = op_ff;
   assign sts.busy      = busy_ff;
   assign sts.full      = (5'(count_ff) >= cap);
   assign sts.pend      = (pend_ff != 5'd0);
   assign sts.prev_data = (prev_ff == PREV_DATA);
   assign sts.q_empty   = (count_ff == '0);
   assign sts.scan_hit  = (ptr_ff <= top) && changed;
   assign sts.scan_done = (ptr_ff > top);

   assign rsp_load = cmd.ovf || cmd.direct || cmd.token ||
                     (cmd.scan_step && sts.scan_hit) || cmd.pop_send;

   lobvl_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock   (clock),
      .wr_en   (cmd.enqueue),
      .wr_addr (slot),
      .wr_data ({vl_ff, lst_ff, tag_ff}),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff  <= in_data[1:0];
         vl_ff  <= in_data[5:2];
         tag_ff <= in_data[37:6];
         lst_ff <= in_data[38];
         cl_ff  <= in_data[50:39];
      end
      if (cmd.ovf || cmd.direct) begin
         rsp_word.kind <= cmd.ovf ? KIND_OVF : KIND_DATA;
         rsp_word.vl <= vl_ff;
         rsp_word.tag <= tag_ff;
         rsp_word.lst <= lst_ff;
         rsp_word.fcb <= '0;
         rsp_word.fcl <= '0;
         rsp_word.last <= cmd.emit_last;
      end
      if (cmd.token) begin
         rsp_word <= '{KIND_TOKEN, 4'd0, 32'd0, 1'b0, 12'd0, 12'd0, cmd.emit_last};
      end
      if (cmd.scan_step && sts.scan_hit) begin
         rsp_word <= '{KIND_FC, si, 32'd0, 1'b0, bs_ff[si], lim_ff[si], cmd.emit_last};
      end
      if (cmd.pop_send) begin
         rsp_word <= '{KIND_DATA, rd_data[36:33], rd_data[31:0], rd_data[32],
                       12'd0, 12'd0, cmd.emit_last};
      end
      if (reset) begin
         max_vl_ff <= '0;
         qsize_ff  <= 5'd16;
         count_ff  <= '0;
         head_ff   <= '0;
         busy_ff   <= 1'b1;
         prev_ff   <= PREV_NONE;
         ptr_ff    <= '0;
         pend_ff   <= '0;
         av_ff     <= '0;
         for (int i = 0; i < NUM_VL; i++) begin
            bs_ff[i] <= '0; lim_ff[i] <= '0; ab_ff[i] <= '0; al_ff[i] <= '0;
         end
      end else begin
         if (csr_we) begin
            if (csr_idx == CSR_MAX_VL) max_vl_ff <= csr_val[3:0];
            else qsize_ff <= csr_val;
         end
         if (cmd.credit && 32'(vl_ff) < NUM_VL) lim_ff[vl_ff] <= cl_ff;
         if (cmd.enqueue) count_ff <= count_ff + 1'b1;
         if (cmd.direct) begin
            prev_ff <= lst_ff ? PREV_LAST : PREV_DATA;
            if (32'(vl_ff) < NUM_VL) bs_ff[vl_ff] <= bs_ff[vl_ff] + 12'd1;
            busy_ff <= 1'b1;
         end
         if (cmd.tick) busy_ff <= 1'b0;
         if (cmd.token) pend_ff <= pend_ff - 5'd1;
         if (cmd.scan_init && ptr_ff > top) ptr_ff <= '0;
         if (cmd.scan_step && !sts.scan_done) begin
            ptr_ff <= ptr_ff + 5'd1;
            if (changed) begin
               av_ff[si] <= 1'b1;
               ab_ff[si] <= bs_ff[si];
               al_ff[si] <= lim_ff[si];
               busy_ff   <= 1'b1;
               prev_ff   <= PREV_FC;
            end
         end
         if (cmd.pop_read) begin
            count_ff <= count_ff - 1'b1;
            if (pend_ff < 5'd31) pend_ff <= pend_ff + 5'd1 - 5'(cmd.token);
         end
         if (cmd.pop_send) begin
            head_ff <= head_ff + 1'b1;
            prev_ff <= rd_data[32] ? PREV_LAST : PREV_DATA;
            if (32'(rd_data[36:33]) < NUM_VL)
               bs_ff[rd_data[36:33]] <= bs_ff[rd_data[36:33]] + 12'd1;
            busy_ff <= 1'b1;
         end
         if (cmd.idle_prev) prev_ff <= PREV_NONE;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/lobvl_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Link output buffer controller
// Sequences each input word through the datapath.
// ----------------------------------------------------------------------------
module lobvl_ctrl import lobvl_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_fire,
   input  wire logic    out_free,
   input  wire sts_type sts,
   output      logic    in_ready,
   output      cmd_type cmd
);
   typedef enum logic [2:0] {
      S_IDLE, S_DECODE, S_SCAN, S_TOKEN, S_FC, S_POP, S_SEND
   } state_type;

   state_type state_ff, state_in;
   logic      hit_ff, hit_in;

   assign in_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      hit_in = hit_ff;
      cmd.latch = in_fire;
      unique case (state_ff)
         S_IDLE: if (in_fire) state_in = S_DECODE;
         S_DECODE: begin
            if (sts.op == OP_DATA) begin
               if (!sts.busy) begin
                  if (out_free) begin cmd.direct = 1'b1; cmd.emit_last = 1'b1;
                     state_in = S_IDLE; end
               end else if (sts.full) begin
                  if (out_free) begin cmd.ovf = 1'b1; cmd.emit_last = 1'b1;
                     state_in = S_IDLE; end
               end else begin
                  cmd.enqueue = 1'b1; state_in = S_IDLE;
               end
            end else if (sts.op == OP_TICK || (sts.op == OP_CREDIT && !sts.busy)) begin
               cmd.credit = (sts.op == OP_CREDIT);
               cmd.tick = 1'b1;
               cmd.scan_init = !sts.prev_data && sts.q_empty;
               hit_in = 1'b0; state_in = S_SCAN;
            end else begin
               cmd.credit = (sts.op == OP_CREDIT);
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            if (sts.prev_data || !sts.q_empty || sts.scan_done) begin
               hit_in = 1'b0; state_in = S_TOKEN;
            end else if (sts.scan_hit) begin
               hit_in = 1'b1; state_in = S_TOKEN;
            end else cmd.scan_step = 1'b1;
         end
         S_TOKEN: begin
            if (sts.pend) begin
               if (out_free) begin
                  cmd.token = 1'b1;
                  cmd.emit_last = !hit_ff && sts.q_empty;
                  state_in = hit_ff ? S_FC : S_POP;
               end
            end else state_in = hit_ff ? S_FC : S_POP;
         end
         S_FC: if (out_free) begin cmd.scan_step = 1'b1; cmd.emit_last = 1'b1;
            state_in = S_IDLE; end
         S_POP: begin
            if (!sts.q_empty) begin cmd.pop_read = 1'b1; state_in = S_SEND; end
            else begin
               cmd.idle_prev = !sts.prev_data;
               state_in = S_IDLE;
            end
         end
         S_SEND: if (out_free) begin cmd.pop_send = 1'b1; cmd.emit_last = 1'b1;
            state_in = S_IDLE; end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         hit_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         hit_ff   <= hit_in;
      end
   end
endmodule
`default_nettype wire

// ===== tb/link_output_buffer_with_vl_flow_control_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Link output buffer testbench
// Drives flits, link-ready ticks and credit limits with random gaps and
// back-pressure, predicts every result word and checks each one in order.
// ----------------------------------------------------------------------------
module link_output_buffer_with_vl_flow_control_test;
   import lobvl_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  vl;
      logic [31:0] tag;
      logic        lst;
      logic [11:0] fcb;
      logic [11:0] fcl;
      logic        last;
   } result_type;

   class port_scoreboard;
      logic [3:0]  max_vl;
      logic [4:0]  queue_size;
      logic [36:0] fifo [QUEUE_DEPTH];
      int          count, head, scan_ptr, pend;
      bit          busy;
      logic [1:0]  prev;
      logic [11:0] sent [NUM_VL];
      logic [11:0] limit [NUM_VL];
      logic [11:0] adv_sent [NUM_VL];
      logic [11:0] adv_limit [NUM_VL];
      bit          adv_ok [NUM_VL];
      result_type  pending_words [$];
      int          errors, produced;

      function void clear();
         max_vl = '0; queue_size = 5'd16; count = 0; head = 0; busy = 1;
         prev = PREV_NONE; scan_ptr = 0; pend = 0; errors = 0; produced = 0;
         for (int i = 0; i < NUM_VL; i++) begin
            sent[i] = '0; limit[i] = '0; adv_sent[i] = '0; adv_limit[i] = '0;
            adv_ok[i] = 0;
         end
      endfunction

      function void push(logic [1:0] k, logic [3:0] v, logic [31:0] t, logic l,
                         logic [11:0] b, logic [11:0] c);
         result_type w;
         w = '{k, v, t, l, b, c, 1'b0};
         pending_words = {pending_words, w};
      endfunction

      function void send_flit(logic [3:0] v, logic [31:0] t, logic l);
         prev = l ? PREV_LAST : PREV_DATA;
         sent[v] = sent[v] + 12'd1;
         busy = 1;
         push(KIND_DATA, v, t, l, 12'd0, 12'd0);
      endfunction

      function bit scan();
         int top;
         int i;
         top = max_vl;
         if (count != 0) return 0;
         if (scan_ptr > top) scan_ptr = 0;
         while (scan_ptr <= top) begin
            i = scan_ptr;
            scan_ptr++;
            if (!adv_ok[i] || adv_sent[i] != sent[i] || adv_limit[i] != limit[i]) begin
               adv_ok[i] = 1; adv_sent[i] = sent[i]; adv_limit[i] = limit[i];
               busy = 1;
               push(KIND_FC, 4'(i), 32'd0, 1'b0, sent[i], limit[i]);
               return 1;
            end
         end
         return 0;
      endfunction

      function void tick();
         logic [36:0] e;
         busy = 0;
         if (pend > 0) begin
            pend--;
            push(KIND_TOKEN, 4'd0, 32'd0, 1'b0, 12'd0, 12'd0);
         end
         if (prev != PREV_DATA && scan()) begin
            prev = PREV_FC;
            return;
         end
         if (count != 0) begin
            e = fifo[head];
            head = (head + 1) % QUEUE_DEPTH;
            count--;
            if (pend < 31) pend++;
            send_flit(e[36:33], e[31:0], e[32]);
         end else if (prev != PREV_DATA) begin
            prev = PREV_NONE;
         end
      endfunction

      function void note_input(logic [1:0] op, logic [3:0] v, logic [31:0] t,
                               logic l, logic [11:0] c);
         int prior_size, cap;
         prior_size = pending_words.size();
         if (op == OP_DATA) begin
            if (busy) begin
               cap = (queue_size > QUEUE_DEPTH) ? QUEUE_DEPTH : queue_size;
               if (count >= cap) push(KIND_OVF, v, t, l, 12'd0, 12'd0);
               else begin
                  fifo[(head + count) % QUEUE_DEPTH] = {v, l, t};
                  count++;
               end
            end else send_flit(v, t, l);
         end else if (op == OP_TICK) begin
            tick();
         end else if (op == OP_CREDIT) begin
            limit[v] = c;
            if (!busy) tick();
         end
         if (pending_words.size() > prior_size)
            pending_words[pending_words.size() - 1].last = 1'b1;
      endfunction

      function void check_word(result_type got);
         result_type exp;
         produced++;
         if (pending_words.size() == 0) begin
            errors++;
            if (errors <= 10) $display("Unexpected word %h", got);
            return;
         end
         exp = pending_words.pop_front();
         if (exp !== got) begin
            errors++;
            if (errors <= 10)
               $display("Mismatch: expected %h, got %h", exp, got);
         end
      endfunction
   endclass

   logic        clock, reset;
   logic        req_tvalid, req_tready;
   logic [55:0] req_tdata;
   logic        rsp_tvalid, rsp_tready;
   logic [63:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid, csr_ready, csr_index;
   logic [4:0]  csr_data;

   port_scoreboard sb;
   int  idle_cycles;
   int  hold_cycles;
   int  sent_items;
   bit  draining;

   link_output_buffer_with_vl_flow_control DUT (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   function int gap();
      if ($urandom_range(0, 3) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      return $urandom_range(0, 3);
   endfunction

   task automatic send_item(logic [1:0] op, logic [3:0] v, logic [31:0] t,
                            logic l, logic [11:0] c);
      int n;
      n = draining ? 0 : gap();
      repeat (n) begin
         @(posedge clock);
         req_tvalid <= 1'b0;
      end
      @(posedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, c, l, t, v, op};
      do @(posedge clock); while (!req_tready);
      sb.note_input(op, v, t, l, c);
      sent_items++;
      req_tvalid <= 1'b0;
   endtask

   task automatic random_item(int bias);
      logic [1:0] op;
      int r;
      r = $urandom_range(0, 99);
      if (r < bias) op = OP_DATA;
      else if (r < 85) op = OP_TICK;
      else if (r < 98) op = OP_CREDIT;
      else op = OP_UNUSED;
      send_item(op, 4'($urandom), $urandom, 1'($urandom), 12'($urandom));
   endtask

   task automatic wait_drained();
      while (sb.pending_words.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [4:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_MAX_VL) sb.max_vl = val[3:0];
      else sb.queue_size = val;
   endtask

   // Receiver: random stalls, plus a long hold-off on request.
   initial begin
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            sb.check_word({rsp_tuser, rsp_tdata[3:0], rsp_tdata[35:4], rsp_tdata[36],
                           rsp_tdata[48:37], rsp_tdata[60:49], rsp_tlast});
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready <= 1'b0;
         end else if (draining) rsp_tready <= 1'b1;
         else rsp_tready <= ($urandom_range(0, 9) < 7);
      end
   end

   initial begin
      idle_cycles = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles > 20000) begin
            $display("Timeout after %0d idle cycles", idle_cycles);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      int seq;
      sb = new();
      sb.clear();
      reset = 1; req_tvalid = 0; req_tdata = 0; csr_valid = 0; csr_index = 0;
      csr_data = 0; hold_cycles = 0; sent_items = 0; draining = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: flits queued before the first tick, overflow, ticks, extremes.
      write_reg(CSR_MAX_VL, 5'd15);
      write_reg(CSR_QUEUE_SIZE, 5'd2);
      send_item(OP_DATA, 4'd0, 32'h0, 1'b0, 12'h0);
      send_item(OP_DATA, 4'd15, 32'hFFFFFFFF, 1'b1, 12'hFFF);
      send_item(OP_DATA, 4'd5, 32'h12345678, 1'b1, 12'h0);
      send_item(OP_UNUSED, 4'd1, 32'h1, 1'b1, 12'h1);
      for (int i = 0; i < 6; i++) send_item(OP_TICK, 4'd0, 32'd0, 1'b0, 12'd0);
      send_item(OP_CREDIT, 4'd15, 32'd0, 1'b0, 12'hFFF);
      send_item(OP_CREDIT, 4'd0, 32'd0, 1'b0, 12'h0);
      for (int i = 0; i < 10; i++) send_item(OP_TICK, 4'd0, 32'd0, 1'b0, 12'd0);
      send_item(OP_DATA, 4'd3, 32'hA5A5A5A5, 1'b0, 12'h0);
      send_item(OP_TICK, 4'd0, 32'd0, 1'b0, 12'd0);
      wait_drained();

      write_reg(CSR_QUEUE_SIZE, 5'd0);
      send_item(OP_DATA, 4'd2, 32'h5A5A5A5A, 1'b0, 12'd0);
      send_item(OP_DATA, 4'd2, 32'h5A5A5A5B, 1'b1, 12'd0);
      wait_drained();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin write_reg(CSR_MAX_VL, 5'd0);  write_reg(CSR_QUEUE_SIZE, 5'd16); end
            1: begin write_reg(CSR_MAX_VL, 5'd3);  write_reg(CSR_QUEUE_SIZE, 5'd1); end
            2: begin write_reg(CSR_MAX_VL, 5'd15); write_reg(CSR_QUEUE_SIZE, 5'd31); end
            3: begin write_reg(CSR_MAX_VL, 5'd7);  write_reg(CSR_QUEUE_SIZE, 5'd4); end
            4: begin
               write_reg(CSR_MAX_VL, 5'($urandom));
               write_reg(CSR_QUEUE_SIZE, 5'($urandom));
            end
            default: begin write_reg(CSR_MAX_VL, 5'd1); write_reg(CSR_QUEUE_SIZE, 5'd16); end
         endcase
         if (ph == 2) hold_cycles = 400;
         for (int i = 0; i < 300; i++) begin
            seq = (ph == 2 && i < 60) ? 80 : 45;
            random_item(seq);
         end
         wait_drained();
      end

      draining = 1;
      wait_drained();
      $display("Sent %0d items and checked %0d result words over six register settings",
               sent_items, sb.produced);
      $display("including overflow, back-pressure and lane-scan cases.");
      if (sb.errors == 0 && sb.pending_words.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("%0d mismatches, %0d words outstanding", sb.errors,
                  sb.pending_words.size());
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
